// ===== hw/rtl/lwpd_pkg.sv =====
package lwpd_pkg;

    localparam int LWPD_LOOKAHEAD_DEPTH = 128;
    localparam int LWPD_DEQUE_DEPTH     = 1024;
    localparam int LWPD_SAMPLE_BITS     = 24;

    localparam int STAMP_BITS   = 16;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;
    localparam int LA_LEN_BITS  = 8;
    localparam int HOLD_BITS    = 10;

    localparam logic [LA_LEN_BITS-1:0] LA_LEN_RESET = 8'd72;
    localparam logic [HOLD_BITS-1:0]   HOLD_RESET   = 10'd552;

    typedef enum logic [1:0] {
        REG_ENABLE    = 2'd0,
        REG_LOOKAHEAD = 2'd1,
        REG_HOLD      = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_BACK,
        S_PUSH,
        S_FRONT_RD,
        S_FRONT,
        S_DONE
    } state_t;

endpackage

// ===== hw/rtl/lwpd_ram.sv =====
module lwpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/lookahead_window_peak_detector.sv =====
// Look-ahead window peak detector. Each sample transfer yields one result: the
// sample from lookahead_len transfers earlier and the largest magnitude seen
// over the last hold_len samples (zero while disabled), kept as a monotonic
// deque of magnitude and tick-stamp entries in a single-port-read synchronous
// memory. With the detector enabled an item runs through start, the back
// checks (skipped when the deque is empty), push, front read and the front
// checks to done, each deque check being one memory read and compare; a
// disabled item goes from start straight to done. A result still held back by
// result_stall keeps the next item from finishing. After reset the delay
// memory is zeroed one entry a cycle, during which no sample is accepted;
// register writes are taken at any time. Registers (byte address): enable at
// 0x0, lookahead_len at 0x4, hold_len at 0x8.
module lookahead_window_peak_detector
    import lwpd_pkg::*;
#(
    parameter int LOOKAHEAD_DEPTH = LWPD_LOOKAHEAD_DEPTH,
    parameter int DEQUE_DEPTH     = LWPD_DEQUE_DEPTH,
    parameter int SAMPLE_BITS     = LWPD_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_AW-1:0]             paddr,
    input  logic [APB_DW-1:0]             pwdata,
    output logic [APB_DW-1:0]             prdata,
    output logic                          pready,

    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [SAMPLE_BITS-1:0] delayed_sample,
    output logic [SAMPLE_BITS-1:0]        window_peak
);

    localparam int LA_AW = $clog2(LOOKAHEAD_DEPTH);
    localparam int LA_CW = (LA_AW + 1 > LA_LEN_BITS) ? LA_AW + 1 : LA_LEN_BITS;
    localparam int DQ_AW = $clog2(DEQUE_DEPTH);
    localparam int DQ_PW = $clog2(2 * DEQUE_DEPTH);
    localparam int HC_W  = (DQ_PW > HOLD_BITS) ? DQ_PW : HOLD_BITS;
    localparam int DQ_W  = SAMPLE_BITS + STAMP_BITS;

    localparam logic [LA_CW-1:0] LA_DEPTH_C  = LA_CW'(LOOKAHEAD_DEPTH);
    localparam logic [LA_AW-1:0] CLR_LAST    = LA_AW'(LOOKAHEAD_DEPTH - 1);
    localparam logic [DQ_PW-1:0] DQ_DEPTH_P  = DQ_PW'(DEQUE_DEPTH);
    localparam logic [DQ_PW-1:0] RING2_P     = DQ_PW'(2 * DEQUE_DEPTH);
    localparam logic [DQ_PW-1:0] RING2_LAST  = DQ_PW'(2 * DEQUE_DEPTH - 1);
    localparam logic [HC_W-1:0]  DQ_DEPTH_H  = HC_W'(DEQUE_DEPTH);

    function automatic logic [DQ_PW-1:0] ring_next(input logic [DQ_PW-1:0] pos);
        ring_next = (pos == RING2_LAST) ? '0 : pos + 1'b1;
    endfunction

    function automatic logic [DQ_PW-1:0] ring_prev(input logic [DQ_PW-1:0] pos);
        ring_prev = (pos == '0) ? RING2_LAST : pos - 1'b1;
    endfunction

    function automatic logic [DQ_AW-1:0] ring_slot(input logic [DQ_PW-1:0] pos);
        logic [DQ_PW-1:0] wrapped;
        wrapped   = (pos >= DQ_DEPTH_P) ? pos - DQ_DEPTH_P : pos;
        ring_slot = wrapped[DQ_AW-1:0];
    endfunction

    // configuration registers
    logic                   enable_reg;
    logic [LA_LEN_BITS-1:0] lookahead_reg;
    logic [HOLD_BITS-1:0]   hold_reg;
    reg_idx_t               reg_idx;
    logic                   cfg_write;

    // control state
    state_t           state_reg, state_next;
    logic [LA_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [LA_AW-1:0] delay_pos_reg, delay_pos_next;
    logic [DQ_PW-1:0] head_reg, head_next;
    logic [DQ_PW-1:0] tail_reg, tail_next;
    logic [STAMP_BITS-1:0] tick_reg, tick_next;
    logic             out_valid_reg, out_valid_next;

    // item payload
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic [SAMPLE_BITS-1:0] delayed_reg;
    logic [SAMPLE_BITS-1:0] peak_reg, peak_next;
    logic [SAMPLE_BITS-1:0] out_delayed_reg;
    logic [SAMPLE_BITS-1:0] out_peak_reg;

    // memories
    logic                   la_we;
    logic [LA_AW-1:0]       la_waddr;
    logic [SAMPLE_BITS-1:0] la_wdata;
    logic [SAMPLE_BITS-1:0] la_rdata;
    logic                   dq_we;
    logic [DQ_AW-1:0]       dq_waddr;
    logic [DQ_W-1:0]        dq_wdata;
    logic [DQ_AW-1:0]       dq_raddr;
    logic [DQ_W-1:0]        dq_rdata;

    // datapath helpers
    logic                   accept;
    logic                   out_load;
    logic [LA_CW-1:0]       la_ext, la_eff, delay_pos_inc;
    logic [HC_W-1:0]        hold_ext, hold_sat;
    logic [HOLD_BITS-1:0]   hold_eff;
    logic [SAMPLE_BITS-1:0] sample_mag;
    logic [DQ_PW-1:0]       dq_count;
    logic [DQ_PW-1:0]       tail_prev, tail_prev2, head_nx;
    logic [SAMPLE_BITS-1:0] dq_value;
    logic [STAMP_BITS-1:0]  dq_stamp;
    logic [STAMP_BITS-1:0]  age;
    logic                   back_pop;
    logic                   front_pop;
    logic                   last_entry;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_idx)
            REG_ENABLE:    prdata = APB_DW'(enable_reg);
            REG_LOOKAHEAD: prdata = APB_DW'(lookahead_reg);
            REG_HOLD:      prdata = APB_DW'(hold_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            lookahead_reg <= LA_LEN_RESET;
            hold_reg      <= HOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_ENABLE:    enable_reg    <= pwdata[0];
                REG_LOOKAHEAD: lookahead_reg <= pwdata[LA_LEN_BITS-1:0];
                REG_HOLD:      hold_reg      <= pwdata[HOLD_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    lwpd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (LOOKAHEAD_DEPTH)
    ) u_delay_ram (
        .clk   (clk),
        .we    (la_we),
        .waddr (la_waddr),
        .wdata (la_wdata),
        .raddr (delay_pos_reg),
        .rdata (la_rdata)
    );

    lwpd_ram #(
        .WIDTH (DQ_W),
        .DEPTH (DEQUE_DEPTH)
    ) u_deque_ram (
        .clk   (clk),
        .we    (dq_we),
        .waddr (dq_waddr),
        .wdata (dq_wdata),
        .raddr (dq_raddr),
        .rdata (dq_rdata)
    );

    // ------------------------------------------------------------------
    // shared combinational terms
    // ------------------------------------------------------------------
    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != S_IDLE);
    assign out_load     = (state_reg == S_DONE) && (!out_valid_reg || !result_stall);

    // lookahead 0 acts as 1, long values saturate at the memory depth
    assign la_ext        = LA_CW'(lookahead_reg);
    assign la_eff        = (la_ext == '0) ? LA_CW'(1) :
                           ((la_ext > LA_DEPTH_C) ? LA_DEPTH_C : la_ext);
    assign delay_pos_inc = LA_CW'(delay_pos_reg) + LA_CW'(1);

    assign hold_ext = HC_W'(hold_reg);
    assign hold_sat = (hold_ext == '0) ? HC_W'(1) :
                      ((hold_ext > DQ_DEPTH_H) ? DQ_DEPTH_H : hold_ext);
    assign hold_eff = hold_sat[HOLD_BITS-1:0];

    // magnitude of the most negative code is exact in SAMPLE_BITS unsigned
    assign sample_mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

    assign dq_count   = (tail_reg < head_reg) ? tail_reg - head_reg + RING2_P
                                              : tail_reg - head_reg;
    assign last_entry = (dq_count == DQ_PW'(1));
    assign tail_prev  = ring_prev(tail_reg);
    assign tail_prev2 = ring_prev(tail_prev);
    assign head_nx    = ring_next(head_reg);

    assign dq_value  = dq_rdata[DQ_W-1:STAMP_BITS];
    assign dq_stamp  = dq_rdata[STAMP_BITS-1:0];
    assign age       = tick_reg - dq_stamp;
    assign back_pop  = (dq_value <= mag_reg);
    assign front_pop = (age >= STAMP_BITS'(hold_eff));

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (!enable_reg)
                begin
                    state_next = S_DONE;
                end
                else if (dq_count != '0)
                begin
                    state_next = S_BACK;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_BACK:
            begin
                if (!back_pop || last_entry)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                state_next = S_FRONT_RD;
            end
            S_FRONT_RD:
            begin
                state_next = S_FRONT;
            end
            S_FRONT:
            begin
                if (!front_pop || last_entry)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and memory control
    // ------------------------------------------------------------------
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        delay_pos_next = delay_pos_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        tick_next      = tick_reg;
        peak_next      = peak_reg;
        la_we          = 1'b0;
        la_waddr       = delay_pos_reg;
        la_wdata       = sample_reg;
        dq_we          = 1'b0;
        dq_waddr       = ring_slot(tail_reg);
        dq_wdata       = {mag_reg, tick_reg};
        dq_raddr       = ring_slot(head_reg);
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && result_stall);

        unique case (state_reg)
            S_CLEAR:
            begin
                la_we        = 1'b1;
                la_waddr     = clr_cnt_reg;
                la_wdata     = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_START:
            begin
                // delay line: old slot was read at accept, now overwrite it
                la_we = 1'b1;
                if (delay_pos_inc >= la_eff)
                begin
                    delay_pos_next = '0;
                end
                else
                begin
                    delay_pos_next = delay_pos_inc[LA_AW-1:0];
                end
                if (!enable_reg)
                begin
                    head_next = '0;
                    tail_next = '0;
                    peak_next = '0;
                end
                else
                begin
                    dq_raddr = ring_slot(tail_prev);
                end
            end
            S_BACK:
            begin
                if (back_pop)
                begin
                    tail_next = tail_prev;
                    dq_raddr  = ring_slot(tail_prev2);
                end
            end
            S_PUSH:
            begin
                // full ring drops its front, which is already out of the window
                if (dq_count == DQ_DEPTH_P)
                begin
                    head_next = head_nx;
                end
                dq_we     = 1'b1;
                tail_next = ring_next(tail_reg);
            end
            S_FRONT_RD:
            begin
                dq_raddr = ring_slot(head_reg);
            end
            S_FRONT:
            begin
                if (front_pop)
                begin
                    head_next = head_nx;
                    dq_raddr  = ring_slot(head_nx);
                    if (last_entry)
                    begin
                        peak_next = '0;
                        tick_next = tick_reg + 1'b1;
                    end
                end
                else
                begin
                    peak_next = dq_value;
                    tick_next = tick_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            delay_pos_reg <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            delay_pos_reg <= delay_pos_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            mag_reg    <= sample_mag;
        end
        if (state_reg == S_START)
        begin
            delayed_reg <= la_rdata;
        end
        peak_reg <= peak_next;
        if (out_load)
        begin
            out_delayed_reg <= delayed_reg;
            out_peak_reg    <= peak_reg;
        end
    end

    assign result_valid   = out_valid_reg;
    assign delayed_sample = out_delayed_reg;
    assign window_peak    = out_peak_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dq_count <= DQ_DEPTH_P)
        else $error("deque holds more entries than the ring");

    a_disabled_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START && !enable_reg) |=> (head_reg == '0 && tail_reg == '0))
        else $error("deque not emptied by a disabled item");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_START))
        else $error("accepted sample did not start processing");

    a_front_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FRONT_RD) |-> (dq_count != '0))
        else $error("front check on an empty deque");

endmodule

// ===== dv/tb_lookahead_window_peak_detector.sv =====
module tb_lookahead_window_peak_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import lwpd_pkg::*;

    localparam int SB              = LWPD_SAMPLE_BITS;
    localparam int DQ_SLOT_BITS    = $clog2(LWPD_DEQUE_DEPTH);
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES   = 16;
    localparam int PHASE_ITEMS     = 12;
    localparam int RAMP_ITEMS      = 1040;

    typedef struct packed {
        logic [SB-1:0] delayed;
        logic [SB-1:0] peak;
    } peak_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef enum int {
        SHAPE_NOISE,
        SHAPE_EXTREME,
        SHAPE_RAMP,
        SHAPE_PLATEAU,
        SHAPE_QUIET
    } shape_t;

    typedef struct {
        row_kind_t    kind;
        reg_idx_t     addr_idx;
        logic [31:0]  value;
        bit           typed;
        peak_result_t want;
    } dir_row_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   psel         = 1'b0;
    logic                   penable      = 1'b0;
    logic                   pwrite       = 1'b0;
    logic [APB_AW-1:0]      paddr        = '0;
    logic [APB_DW-1:0]      pwdata       = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;
    logic                   sample_valid = 1'b0;
    logic                   sample_stall;
    logic signed [SB-1:0]   sample       = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic signed [SB-1:0]   delayed_sample;
    logic [SB-1:0]          window_peak;

    // model of the block's state and registers
    bit                     cfg_enable = 1'b0;
    logic [LA_LEN_BITS-1:0] cfg_la     = LA_LEN_RESET;
    logic [HOLD_BITS-1:0]   cfg_hold   = HOLD_RESET;
    logic [SB-1:0]          dly_mem [LWPD_LOOKAHEAD_DEPTH] = '{default: '0};
    int unsigned            dly_pos    = 0;
    logic [SB-1:0]          dq_mag   [LWPD_DEQUE_DEPTH];
    logic [STAMP_BITS-1:0]  dq_stamp [LWPD_DEQUE_DEPTH];
    logic [DQ_SLOT_BITS:0]  dq_head    = '0;
    logic [DQ_SLOT_BITS:0]  dq_tail    = '0;
    logic [STAMP_BITS-1:0]  tick       = '0;

    peak_result_t           peak_results_due [$];
    int                     mismatch_count = 0;
    bit                     idle_on        = 1'b1;
    bit                     hold_off_req   = 1'b0;
    int                     stall_left     = 0;

    dir_row_t directed_rows [29] = '{
        '{ROW_SAMPLE, REG_ENABLE,    32'h7FFFFF, 1'b1, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'h800000, 1'b1, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'h000001, 1'b1, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'hFFFFFF, 1'b1, '{24'h0, 24'h0}},
        '{ROW_WRITE,  REG_ENABLE,    32'd1,      1'b0, '{24'h0, 24'h0}},
        // zero look-ahead and zero hold act as one
        '{ROW_WRITE,  REG_LOOKAHEAD, 32'd0,      1'b0, '{24'h0, 24'h0}},
        '{ROW_WRITE,  REG_HOLD,      32'd0,      1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'h800000, 1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'h7FFFFF, 1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'h000000, 1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'hFFFFFF, 1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'h000001, 1'b0, '{24'h0, 24'h0}},
        // look-ahead above the line depth saturates
        '{ROW_WRITE,  REG_LOOKAHEAD, 32'd255,    1'b0, '{24'h0, 24'h0}},
        '{ROW_WRITE,  REG_HOLD,      32'd2,      1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'h123456, 1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'h123456, 1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'hEDCBAA, 1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'h123456, 1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'h800000, 1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'h7FFFFF, 1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'hFFFFFF, 1'b0, '{24'h0, 24'h0}},
        '{ROW_WRITE,  REG_LOOKAHEAD, 32'd128,    1'b0, '{24'h0, 24'h0}},
        '{ROW_WRITE,  REG_HOLD,      32'd1023,   1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'h400000, 1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'h3FFFFF, 1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'hC00001, 1'b0, '{24'h0, 24'h0}},
        // disabled: the delay line keeps running, the peak reads zero
        '{ROW_WRITE,  REG_ENABLE,    32'd0,      1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'h7FFFFF, 1'b0, '{24'h0, 24'h0}},
        '{ROW_SAMPLE, REG_ENABLE,    32'h800000, 1'b0, '{24'h0, 24'h0}}
    };

    lookahead_window_peak_detector dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .delayed_sample (delayed_sample),
        .window_peak    (window_peak)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [DQ_SLOT_BITS:0] dq_count();
        return dq_tail - dq_head;
    endfunction

    function automatic peak_result_t predict_peak_result(logic [SB-1:0] s);
        peak_result_t          r;
        int unsigned           la;
        int unsigned           hold;
        int unsigned           idx;
        logic [SB-1:0]         mag;
        logic [DQ_SLOT_BITS:0] prev;
        logic [STAMP_BITS-1:0] age;
        la = (cfg_la == 0) ? 1 : cfg_la;
        if (la > LWPD_LOOKAHEAD_DEPTH)
            la = LWPD_LOOKAHEAD_DEPTH;
        idx = dly_pos % LWPD_LOOKAHEAD_DEPTH;
        r.delayed = dly_mem[idx];
        r.peak = '0;
        dly_mem[idx] = s;
        dly_pos = idx + 1;
        // a position past a shortened line is used once, then wraps
        if (dly_pos >= la)
            dly_pos = 0;
        if (cfg_enable)
        begin
            hold = (cfg_hold == 0) ? 1 : cfg_hold;
            if (hold > LWPD_DEQUE_DEPTH)
                hold = LWPD_DEQUE_DEPTH;
            mag = s[SB-1] ? (~s + 1'b1) : s;
            // pop smaller or equal magnitudes from the back
            while (dq_count() != 0)
            begin
                prev = dq_tail - 1'b1;
                if (dq_mag[prev[DQ_SLOT_BITS-1:0]] > mag)
                    break;
                dq_tail = prev;
            end
            if (dq_count() >= LWPD_DEQUE_DEPTH)
                dq_head = dq_head + 1'b1;
            dq_mag[dq_tail[DQ_SLOT_BITS-1:0]] = mag;
            dq_stamp[dq_tail[DQ_SLOT_BITS-1:0]] = tick;
            dq_tail = dq_tail + 1'b1;
            // expire entries whose age reached the window length
            while (dq_count() != 0)
            begin
                age = tick - dq_stamp[dq_head[DQ_SLOT_BITS-1:0]];
                if (age < hold)
                    break;
                dq_head = dq_head + 1'b1;
            end
            tick = tick + 1'b1;
            if (dq_count() != 0)
                r.peak = dq_mag[dq_head[DQ_SLOT_BITS-1:0]];
        end
        else
        begin
            dq_head = '0;
            dq_tail = '0;
        end
        return r;
    endfunction

    function automatic logic [APB_DW-1:0] reg_mask(reg_idx_t idx);
        case (idx)
            REG_ENABLE:    return 32'd1;
            REG_LOOKAHEAD: return (32'd1 << LA_LEN_BITS) - 1;
            default:       return (32'd1 << HOLD_BITS) - 1;
        endcase
    endfunction

    function automatic logic [SB-1:0] shaped_sample(shape_t shape, int k, logic [SB-1:0] base,
                                                    int unsigned dec);
        logic [SB-1:0] mag;
        logic [SB-1:0] corners [6];
        corners = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h800001};
        case (shape)
            SHAPE_NOISE:   return SB'($urandom);
            SHAPE_EXTREME: return corners[$urandom_range(0, 5)];
            SHAPE_RAMP:
            begin
                mag = (int'(base) > k * dec) ? base - SB'(k * dec) : '0;
                return $urandom_range(0, 1) ? -mag : mag;
            end
            SHAPE_PLATEAU: return $urandom_range(0, 1) ? -base : base;
            default:
            begin
                mag = SB'($urandom_range(0, 15));
                return $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // write one register, then read it back; starts and ends at a falling edge
    task automatic write_register(reg_idx_t idx, logic [31:0] value);
        logic [31:0] data;
        data = (value & reg_mask(idx)) | ($urandom_range(0, 1) ? ($urandom & ~reg_mask(idx)) : 0);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_ENABLE:    cfg_enable = data[0];
            REG_LOOKAHEAD: cfg_la = data[LA_LEN_BITS-1:0];
            default:       cfg_hold = data[HOLD_BITS-1:0];
        endcase
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== (data & reg_mask(idx)))
            flag_mismatch("register readback", prdata, data & reg_mask(idx));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (peak_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(bit en, int la, int hold);
        wait_idle();
        write_register(REG_LOOKAHEAD, 32'(la));
        write_register(REG_HOLD, 32'(hold));
        write_register(REG_ENABLE, 32'(en));
    endtask

    // offer one sample until it transfers; starts and ends at a falling edge
    task automatic send_sample(logic [SB-1:0] s, bit typed, peak_result_t typed_res);
        peak_result_t r;
        sample_valid <= 1'b1;
        sample <= s;
        do @(posedge clk); while (sample_stall);
        r = predict_peak_result(s);
        peak_results_due.push_back(typed ? typed_res : r);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else if (hold_off_req)
        begin
            // long hold-off so the block backs up into its input
            hold_off_req = 1'b0;
            stall_left = HOLD_OFF_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        peak_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (peak_results_due.size() == 0)
                flag_mismatch("unexpected result", 32'(delayed_sample), 32'(window_peak));
            else
            begin
                want = peak_results_due.pop_front();
                if (delayed_sample !== want.delayed)
                    flag_mismatch("delayed_sample", 32'(delayed_sample), 32'(want.delayed));
                if (window_peak !== want.peak)
                    flag_mismatch("window_peak", 32'(window_peak), 32'(want.peak));
            end
        end
    end

    initial
    begin
        #10ms;
        $display("tb_lookahead_window_peak_detector: FAIL");
        $finish;
    end

    initial
    begin
        int           la_pick   [10];
        int           hold_pick [10];
        int           n_done;
        int           seg_len;
        int           la_v;
        int           hold_v;
        shape_t       shape;
        logic [SB-1:0] base;
        int unsigned  dec;
        peak_result_t blank;
        la_pick   = '{1, 255, 0, 0, 128, 129, 2, -1, -1, 72};
        hold_pick = '{1023, 2, 0, 0, 1, 1020, 3, -1, -1, 1021};
        blank = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                if (i == 0 || directed_rows[i-1].kind != ROW_WRITE)
                    wait_idle();
                write_register(directed_rows[i].addr_idx, directed_rows[i].value);
            end
            else
                send_sample(directed_rows[i].value[SB-1:0], directed_rows[i].typed,
                            directed_rows[i].want);
        end

        for (int p = 0; p < 10; p++)
        begin
            idle_on = (p != 5 && p != 9);
            if (p == 3)
            begin
                // strictly falling magnitudes fill the deque to the window length,
                // then one full-scale sample empties it from the back
                configure(1'b1, $urandom_range(1, 128), 1023);
                for (int k = 0; k < RAMP_ITEMS; k++)
                    send_sample(shaped_sample(SHAPE_RAMP, k, 24'h7FF000, 97), 1'b0, blank);
                send_sample(24'h800000, 1'b0, blank);
                for (int k = 0; k < 20; k++)
                    send_sample(shaped_sample(SHAPE_NOISE, k, '0, 0), 1'b0, blank);
                continue;
            end
            la_v = (la_pick[p] < 0) ? $urandom_range(1, 128) : la_pick[p];
            hold_v = (hold_pick[p] < 0) ? $urandom_range(2, 64) : hold_pick[p];
            configure(p != 6, la_v, hold_v);
            n_done = 0;
            while (n_done < PHASE_ITEMS)
            begin
                shape = shape_t'($urandom_range(0, 4));
                seg_len = $urandom_range(4, 24);
                base = SB'($urandom_range(0, 24'h800000));
                dec = $urandom_range(1, base / seg_len + 1);
                for (int k = 0; k < seg_len; k++)
                begin
                    if (p == 1 && n_done == 10)
                        hold_off_req = 1'b1;
                    send_sample(shaped_sample(shape, k, base, dec), 1'b0, blank);
                    n_done++;
                end
            end
        end

        sample_valid <= 1'b0;
        while (peak_results_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_lookahead_window_peak_detector: PASS");
        else
            $display("tb_lookahead_window_peak_detector: FAIL");
        $finish;
    end

endmodule
